// ===== design/abs_pkg.sv =====
package abs_pkg;

	// Event codes carried on the cmd port.
	localparam logic [1:0] CMD_MSG   = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_TIMER = 2'd2;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned MSG_BYTES       = 20;
	localparam int unsigned SUM_W           = 13;

	typedef enum logic [1:0] {
		EV_MSG,
		EV_ACK,
		EV_TIMEOUT,
		EV_IGNORE
	} evt_kind_t;

	// One message with its precomputed payload byte sum.
	typedef struct packed {
		logic [63:0]              lo;
		logic [63:0]              mid;
		logic [31:0]              hi;
		logic signed [SUM_W-1:0]  sum;
	} msg_t;

	typedef struct packed {
		evt_kind_t kind;
		logic      ack_number;
		msg_t      msg;
	} evt_t;

	typedef struct packed {
		logic                     send_valid;
		logic                     pkt_seq;
		logic                     pkt_ack;
		logic signed [SUM_W-1:0]  pkt_sum;
		logic [63:0]              pkt_bytes_lo;
		logic [63:0]              pkt_bytes_mid;
		logic [31:0]              pkt_bytes_hi;
		logic                     timer_start;
		logic                     timer_stop;
		logic                     dropped;
	} res_t;

	// Sum of the 20 payload bytes taken as signed values: five groups of four,
	// then the five partial sums.
	function automatic logic signed [SUM_W-1:0] payload_sum(
		logic [63:0] lo,
		logic [63:0] mid,
		logic [31:0] hi
	);
		logic [8*MSG_BYTES-1:0]  pay;
		logic [7:0]              bt;
		logic [SUM_W-1:0]        part [5];
		logic [SUM_W-1:0]        total;
		pay   = {hi, mid, lo};
		total = '0;
		for (int g = 0; g < 5; g++) begin
			part[g] = '0;
			for (int b = 0; b < 4; b++) begin
				bt      = pay[(g*4+b)*8 +: 8];
				part[g] = part[g] + {{(SUM_W-8){bt[7]}}, bt};
			end
		end
		for (int g = 0; g < 5; g++) begin
			total = total + part[g];
		end
		return signed'(total);
	endfunction

endpackage

// ===== design/abs_front.sv =====
module abs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      cmd,
	input  logic [63:0]     msg_bytes_lo,
	input  logic [63:0]     msg_bytes_mid,
	input  logic [31:0]     msg_bytes_hi,
	input  logic            ack_number,
	output logic            evt_valid,
	output abs_pkg::evt_t   evt,
	input  logic            evt_take
);
	import abs_pkg::*;

	evt_t        ent_q [2];
	evt_t        incoming;
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        accept;

	// Classify the word and fold its payload into a byte sum on the way in.
	always_comb begin
		incoming            = '0;
		incoming.ack_number = ack_number;
		incoming.msg.lo     = msg_bytes_lo;
		incoming.msg.mid    = msg_bytes_mid;
		incoming.msg.hi     = msg_bytes_hi;
		incoming.msg.sum    = payload_sum(msg_bytes_lo, msg_bytes_mid, msg_bytes_hi);
		case (cmd)
			CMD_MSG:   incoming.kind = EV_MSG;
			CMD_ACK:   incoming.kind = EV_ACK;
			CMD_TIMER: incoming.kind = EV_TIMEOUT;
			default:   incoming.kind = EV_IGNORE;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign accept    = push && !full;
	assign evt_valid = (count_q != 2'd0);
	assign evt       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (evt_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, accept} - {1'b0, evt_take};
		end
	end

endmodule

// ===== design/abs_core.sv =====
module abs_core #(
	parameter int unsigned QUEUE_DEPTH = abs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            evt_valid,
	input  abs_pkg::evt_t   evt,
	output logic            evt_take,
	input  logic            rq_full,
	output logic            rq_write,
	output abs_pkg::res_t   res
);
	import abs_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	msg_t              mem [QUEUE_DEPTH];
	msg_t              rdata_q;
	msg_t              bypass_data_q;
	logic              bypass_q;
	msg_t              head_msg;
	msg_t              last_q;
	msg_t              last_d;
	msg_t              emit_msg;
	logic              ready_q;
	logic              ready_d;
	logic              seq_q;
	logic              seq_d;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  head_d;
	logic [PTR_W-1:0]  tail_q;
	logic [PTR_W-1:0]  tail_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              wr_en;
	logic              emit;

	// The next head entry is read into a register ahead of use; a write to that
	// slot in the same cycle is forwarded instead.
	assign head_msg = bypass_q ? bypass_data_q : rdata_q;

	assign evt_take = evt_valid && !rq_full;
	assign rq_write = evt_take;

	always_comb begin
		ready_d  = ready_q;
		seq_d    = seq_q;
		last_d   = last_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		wr_en    = 1'b0;
		emit     = 1'b0;
		emit_msg = last_q;
		res      = '0;
		if (evt_take) begin
			case (evt.kind)
				EV_MSG: begin
					if (ready_q) begin
						last_d   = evt.msg;
						ready_d  = 1'b0;
						emit     = 1'b1;
						emit_msg = evt.msg;
					end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
						res.dropped = 1'b1;
					end else begin
						wr_en   = 1'b1;
						tail_d  = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				EV_ACK: begin
					if (!ready_q) begin
						if (evt.ack_number == seq_q) begin
							res.timer_stop = 1'b1;
							seq_d          = ~seq_q;
							if (count_q != '0) begin
								last_d   = head_msg;
								head_d   = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ?
									'0 : head_q + 1'b1;
								count_d  = count_q - 1'b1;
								emit     = 1'b1;
								emit_msg = head_msg;
							end else begin
								ready_d = 1'b1;
							end
						end else begin
							emit = 1'b1;
						end
					end
				end
				EV_TIMEOUT: begin
					if (!ready_q) begin
						emit = 1'b1;
					end
				end
				EV_IGNORE: ;
				default: ;
			endcase
		end
		if (emit) begin
			res.send_valid    = 1'b1;
			res.pkt_seq       = seq_d;
			res.pkt_ack       = seq_d;
			res.pkt_sum       = emit_msg.sum + SUM_W'({seq_d, 1'b0});
			res.pkt_bytes_lo  = emit_msg.lo;
			res.pkt_bytes_mid = emit_msg.mid;
			res.pkt_bytes_hi  = emit_msg.hi;
			res.timer_start   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= evt.msg;
		end
		rdata_q       <= mem[head_d];
		bypass_data_q <= evt.msg;
		last_q        <= last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q  <= 1'b1;
			seq_q    <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			bypass_q <= 1'b0;
		end else begin
			ready_q  <= ready_d;
			seq_q    <= seq_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			bypass_q <= wr_en && (tail_q == head_d);
		end
	end

	// The message queue never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("message queue over-filled");

	// While the sender is ready nothing may be waiting in the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (count_q == '0))
		else $error("sender ready with queued messages");

	// A timer stop without a new packet leaves the sender ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rq_write && res.timer_stop && !res.send_valid) |=> ready_q)
		else $error("acknowledged sender not ready");

	// Every packet sent restarts the timer and leaves the sender not ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rq_write && res.send_valid) |=> !ready_q)
		else $error("sender ready with a packet outstanding");

endmodule

// ===== design/abs_rq.sv =====
module abs_rq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            write,
	input  abs_pkg::res_t   wdata,
	output logic            rq_full,
	output logic            empty,
	input  logic            pop,
	output abs_pkg::res_t   rdata
);
	import abs_pkg::*;

	res_t        ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        take;

	assign rq_full = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign take    = pop && !empty;
	assign rdata   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (write) begin
			ent_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (write) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, write} - {1'b0, take};
		end
	end

endmodule

// ===== design/alternating_bit_sender.sv =====
// Alternating-bit stop-and-wait sender.
// Input channel: a word is taken when push is high and full is low. cmd picks
// a message from the application (with its 20 payload bytes), an arriving
// acknowledgement (ack_number) or a retransmission timer expiry.
// Result channel: while empty is low the oldest result word is on the result
// ports; it is taken when pop is high. Exactly one result word is produced per
// input word, carrying the packet to send (if any), the timer start and stop
// requests and the drop flag.
// Throughput: one word per cycle while the output queue has room, set by the
// single decision step in the back end that updates the sequence bit and the
// message queue. A two-word queue at the input and another at the output let
// either side stall on its own; when pop is held low the output queue fills,
// the back end stops, and full rises once the input queue is also occupied.
// At reset the sender is ready with sequence bit zero, and both word queues
// and the message queue are emptied; the storage itself is not cleared.
module alternating_bit_sender #(
	parameter int unsigned QUEUE_DEPTH = abs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          cmd,
	input  logic [63:0]         msg_bytes_lo,
	input  logic [63:0]         msg_bytes_mid,
	input  logic [31:0]         msg_bytes_hi,
	input  logic                ack_number,
	output logic                empty,
	input  logic                pop,
	output logic                send_valid,
	output logic                pkt_seq,
	output logic                pkt_ack,
	output logic signed [12:0]  pkt_sum,
	output logic [63:0]         pkt_bytes_lo,
	output logic [63:0]         pkt_bytes_mid,
	output logic [31:0]         pkt_bytes_hi,
	output logic                timer_start,
	output logic                timer_stop,
	output logic                dropped
);
	import abs_pkg::*;

	evt_t  evt;
	logic  evt_valid;
	logic  evt_take;
	res_t  core_res;
	res_t  out_res;
	logic  rq_write;
	logic  rq_full;

	// Front end: accepts and classifies words and precomputes the byte sum.
	abs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.msg_bytes_lo  (msg_bytes_lo),
		.msg_bytes_mid (msg_bytes_mid),
		.msg_bytes_hi  (msg_bytes_hi),
		.ack_number    (ack_number),
		.evt_valid     (evt_valid),
		.evt           (evt),
		.evt_take      (evt_take)
	);

	// Back end: protocol state and the queue of waiting messages.
	abs_core #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt       (evt),
		.evt_take  (evt_take),
		.rq_full   (rq_full),
		.rq_write  (rq_write),
		.res       (core_res)
	);

	// Result words wait here until the receiver pops them.
	abs_rq u_rq (
		.clk     (clk),
		.arst_n  (arst_n),
		.write   (rq_write),
		.wdata   (core_res),
		.rq_full (rq_full),
		.empty   (empty),
		.pop     (pop),
		.rdata   (out_res)
	);

	assign send_valid    = out_res.send_valid;
	assign pkt_seq       = out_res.pkt_seq;
	assign pkt_ack       = out_res.pkt_ack;
	assign pkt_sum       = out_res.pkt_sum;
	assign pkt_bytes_lo  = out_res.pkt_bytes_lo;
	assign pkt_bytes_mid = out_res.pkt_bytes_mid;
	assign pkt_bytes_hi  = out_res.pkt_bytes_hi;
	assign timer_start   = out_res.timer_start;
	assign timer_stop    = out_res.timer_stop;
	assign dropped       = out_res.dropped;

endmodule

// ===== dv/abs_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
package abs_scoreboard_pkg;
	import abs_pkg::*;

	// The one cmd encoding that the sender must ignore.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] mid;
		logic [31:0] hi;
	} payload_t;

	class packet_scoreboard;
		logic        ready;
		logic        seq_bit;
		payload_t    last_sent;
		payload_t    backlog[$];
		int unsigned backlog_depth;
		res_t        packets_due[$];
		int unsigned n_events;
		int unsigned n_packets;
		int unsigned n_resends;
		int unsigned n_restarts;
		int unsigned n_drops;
		int unsigned n_checked;
		int unsigned n_errors;

		function new(int unsigned depth);
			backlog_depth = depth;
			ready         = 1'b1;
			seq_bit       = 1'b0;
			last_sent     = '0;
			n_events      = 0;
			n_packets     = 0;
			n_resends     = 0;
			n_restarts    = 0;
			n_drops       = 0;
			n_checked     = 0;
			n_errors      = 0;
		endfunction

		// Checksum: seq plus ack plus every payload byte as a signed value.
		function logic [12:0] checksum();
			logic [159:0] pay;
			int           total;
			pay   = {last_sent.hi, last_sent.mid, last_sent.lo};
			total = 2 * int'(seq_bit);
			for (int i = 0; i < 20; i++) begin
				total = total + int'($signed(pay[i*8 +: 8]));
			end
			return total[12:0];
		endfunction

		// Puts the last message on the wire with the current bit and starts the timer.
		function void load_packet(inout res_t r);
			r.send_valid    = 1'b1;
			r.pkt_seq       = seq_bit;
			r.pkt_ack       = seq_bit;
			r.pkt_sum       = checksum();
			r.pkt_bytes_lo  = last_sent.lo;
			r.pkt_bytes_mid = last_sent.mid;
			r.pkt_bytes_hi  = last_sent.hi;
			r.timer_start   = 1'b1;
		endfunction

		function void take_event(logic [1:0] c, payload_t p, logic ackn);
			res_t r;
			r = '0;
			n_events++;
			case (c)
				CMD_MSG: begin
					if (ready) begin
						last_sent = p;
						ready     = 1'b0;
						load_packet(r);
						n_packets++;
					end else if (backlog.size() >= backlog_depth) begin
						r.dropped = 1'b1;
						n_drops++;
					end else begin
						backlog.push_back(p);
					end
				end
				CMD_ACK: begin
					if (!ready && ackn == seq_bit) begin
						r.timer_stop = 1'b1;
						seq_bit      = ~seq_bit;
						ready        = 1'b1;
						if (backlog.size() > 0) begin
							last_sent = backlog.pop_front();
							ready     = 1'b0;
							load_packet(r);
							n_packets++;
							n_restarts++;
						end
					end else if (!ready) begin
						load_packet(r);
						n_resends++;
					end
				end
				CMD_TIMER: begin
					if (!ready) begin
						load_packet(r);
						n_resends++;
					end
				end
				default: begin
				end
			endcase
			packets_due.push_back(r);
		endfunction

		function void match_field(string field, logic [63:0] want_v, logic [63:0] got_v);
			if (got_v !== want_v) begin
				$error("%s: expected %0h, got %0h", field, want_v, got_v);
				n_errors++;
			end
		endfunction

		function void check_packet(res_t got);
			res_t want;
			if (packets_due.size() == 0) begin
				$error("result word arrived with nothing expected");
				n_errors++;
				return;
			end
			want = packets_due.pop_front();
			n_checked++;
			match_field("send_valid", want.send_valid, got.send_valid);
			match_field("pkt_seq", want.pkt_seq, got.pkt_seq);
			match_field("pkt_ack", want.pkt_ack, got.pkt_ack);
			match_field("pkt_sum", want.pkt_sum, got.pkt_sum);
			match_field("pkt_bytes_lo", want.pkt_bytes_lo, got.pkt_bytes_lo);
			match_field("pkt_bytes_mid", want.pkt_bytes_mid, got.pkt_bytes_mid);
			match_field("pkt_bytes_hi", want.pkt_bytes_hi, got.pkt_bytes_hi);
			match_field("timer_start", want.timer_start, got.timer_start);
			match_field("timer_stop", want.timer_stop, got.timer_stop);
			match_field("dropped", want.dropped, got.dropped);
		endfunction
	endclass

endpackage

// ===== dv/alternating_bit_sender_test.sv =====
`timescale 1ns / 1ps
module alternating_bit_sender_test;
	import abs_pkg::*;
	import abs_scoreboard_pkg::*;

	// Random events that actually exercise the sender; ignored ones do not count.
	localparam int unsigned RANDOM_EVENTS = 2000;
	// Far above the slowest legal run.
	localparam int unsigned CYCLE_LIMIT   = 400000;
	// A short wait after the last expectation is met catches any stray extra word.
	localparam int unsigned DRAIN_CYCLES  = 16;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [1:0]         cmd;
	logic [63:0]        msg_bytes_lo;
	logic [63:0]        msg_bytes_mid;
	logic [31:0]        msg_bytes_hi;
	logic               ack_number;
	logic               empty;
	logic               pop;
	logic               send_valid;
	logic               pkt_seq;
	logic               pkt_ack;
	logic signed [12:0] pkt_sum;
	logic [63:0]        pkt_bytes_lo;
	logic [63:0]        pkt_bytes_mid;
	logic [31:0]        pkt_bytes_hi;
	logic               timer_start;
	logic               timer_stop;
	logic               dropped;

	packet_scoreboard board;
	int unsigned      burst_left;
	int unsigned      cycle_count;

	alternating_bit_sender i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.msg_bytes_lo  (msg_bytes_lo),
		.msg_bytes_mid (msg_bytes_mid),
		.msg_bytes_hi  (msg_bytes_hi),
		.ack_number    (ack_number),
		.empty         (empty),
		.pop           (pop),
		.send_valid    (send_valid),
		.pkt_seq       (pkt_seq),
		.pkt_ack       (pkt_ack),
		.pkt_sum       (pkt_sum),
		.pkt_bytes_lo  (pkt_bytes_lo),
		.pkt_bytes_mid (pkt_bytes_mid),
		.pkt_bytes_hi  (pkt_bytes_hi),
		.timer_start   (timer_start),
		.timer_stop    (timer_stop),
		.dropped       (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Payloads lean towards the byte values that stress the signed checksum:
	// zero, the largest positive, the most negative and minus one.
	function automatic payload_t random_payload();
		logic [31:0]  extremes;
		logic [159:0] bits;
		logic [7:0]   one_byte;
		extremes = 32'hFF807F00;
		bits     = {$urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 3))
			2: begin
				for (int i = 0; i < 20; i++) begin
					bits[i*8 +: 8] = extremes[8*$urandom_range(0, 3) +: 8];
				end
			end
			3: begin
				one_byte = extremes[8*$urandom_range(0, 3) +: 8];
				bits     = {20{one_byte}};
			end
			default: begin
			end
		endcase
		return payload_t'(bits);
	endfunction

	// Offers one word and holds it until the block takes it. The sender works
	// in bursts; between bursts push may drop for a random number of cycles.
	task automatic offer_event(input logic [1:0] c, input payload_t p, input logic ackn);
		int unsigned gap;
		cmd           = c;
		msg_bytes_lo  = p.lo;
		msg_bytes_mid = p.mid;
		msg_bytes_hi  = p.hi;
		ack_number    = ackn;
		push          = 1'b1;
		do @(posedge clk); while (full);
		board.take_event(c, p, ackn);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			// Now and then a long burst with no gap at all, otherwise short ones.
			if ($urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(40, 120);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap        = $urandom_range(0, 5);
			end
			if (gap > 0) begin
				push = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Picks an event that makes sense for the sender's present state. Most
	// events drive the protocol forward; wrong ACKs, timer expiries, events
	// while idle and the unused code are the noise around them. In flood mode
	// messages outrun the ACKs, so the backlog fills up and starts dropping.
	task automatic random_event(input bit flood, output bit counted);
		int unsigned roll;
		int unsigned msg_share;
		payload_t    p;
		logic [1:0]  c;
		logic        ackn;
		p         = random_payload();
		ackn      = 1'($urandom_range(0, 1));
		roll      = $urandom_range(0, 99);
		msg_share = flood ? 70 : 25;
		if (board.ready) begin
			if (roll < 85) begin
				c = CMD_MSG;
			end else if (roll < 91) begin
				c = CMD_ACK;
			end else if (roll < 97) begin
				c = CMD_TIMER;
			end else begin
				c = CMD_UNUSED;
			end
		end else begin
			if (roll < msg_share) begin
				c = CMD_MSG;
			end else if (roll < 90) begin
				c    = CMD_ACK;
				ackn = board.seq_bit;
			end else if (roll < 94) begin
				c    = CMD_ACK;
				ackn = ~board.seq_bit;
			end else if (roll < 98) begin
				c = CMD_TIMER;
			end else begin
				c = CMD_UNUSED;
			end
		end
		// An ACK or an expiry with nothing outstanding does nothing, nor does
		// the unused code; such words are offered but not counted.
		counted = !(c == CMD_UNUSED || (board.ready && c != CMD_MSG));
		offer_event(c, p, ackn);
	endtask

	// Every word that leaves the block is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			board.check_packet(res_t'{send_valid, pkt_seq, pkt_ack, pkt_sum, pkt_bytes_lo,
				pkt_bytes_mid, pkt_bytes_hi, timer_start, timer_stop, dropped});
		end
	end

	// The receiver stalls on a pattern picked at random from four: always
	// ready, a coin toss, a fixed three-in-seven stall, or mostly ready. Twice
	// it holds pop low for a long stretch so that both word queues fill and
	// full pushes back on the sender.
	initial begin : receiver
		int unsigned rx_cycle;
		int unsigned hold_left;
		int unsigned mode;
		rx_cycle  = 0;
		hold_left = 0;
		mode      = 0;
		pop       = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % 256 == 0) begin
				mode = $urandom_range(0, 3);
			end
			if (rx_cycle == 400 || rx_cycle == 1500) begin
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop = 1'b0;
			end else begin
				case (mode)
					0: pop = 1'b1;
					1: pop = 1'($urandom_range(0, 1));
					2: pop = (rx_cycle % 7) >= 3;
					default: pop = $urandom_range(0, 99) < 85;
				endcase
			end
		end
	end

	// Watchdog: a run that has not ended by the limit has hung.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		payload_t    p;
		bit          counted;
		bit          flood;
		int unsigned n_counted;
		board         = new(QUEUE_DEPTH_DEF);
		arst_n        = 1'b0;
		push          = 1'b0;
		cmd           = CMD_MSG;
		msg_bytes_lo  = '0;
		msg_bytes_mid = '0;
		msg_bytes_hi  = '0;
		ack_number    = 1'b0;
		burst_left    = 8;
		n_counted     = 0;
		flood         = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Straight after reset nothing is outstanding, so an ACK, an expiry
		// and the unused code must all be ignored, whatever their other bits.
		offer_event(CMD_ACK, '1, 1'b0);
		offer_event(CMD_TIMER, '1, 1'b1);
		offer_event(CMD_UNUSED, '1, 1'b1);
		// The first message goes out at once, with an all-zero payload.
		offer_event(CMD_MSG, '0, 1'b0);
		// The sender is now busy: fill the backlog to the brim, starting with
		// the all-ones, largest positive and most negative payloads.
		for (int k = 0; k < QUEUE_DEPTH_DEF; k++) begin
			case (k)
				0: p = '1;
				1: p = {20{8'h7F}};
				2: p = {20{8'h80}};
				default: p = random_payload();
			endcase
			offer_event(CMD_MSG, p, 1'(k));
		end
		// One more message than the backlog holds is dropped.
		offer_event(CMD_MSG, '1, 1'b0);
		// A wrong ACK and an expiry both resend; the unused code is ignored.
		offer_event(CMD_ACK, '0, ~board.seq_bit);
		offer_event(CMD_TIMER, '0, 1'b0);
		offer_event(CMD_UNUSED, '0, 1'b0);
		// A matching ACK stops the timer and at once sends the oldest queued
		// message with the flipped bit, restarting the timer in the same word.
		offer_event(CMD_ACK, '0, board.seq_bit);

		while (n_counted < RANDOM_EVENTS) begin
			if (n_counted % 150 == 0) begin
				flood = $urandom_range(0, 3) == 0;
			end
			random_event(flood, counted);
			if (counted) begin
				n_counted++;
			end
		end
		push = 1'b0;

		while (board.packets_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d words: %0d packets sent, %0d resent, %0d sent on an ACK,",
			board.n_events, board.n_packets, board.n_resends, board.n_restarts);
		$display("%0d messages dropped on a full backlog, %0d result words checked.",
			board.n_drops, board.n_checked);
		if (board.n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
